### design/sbe_pkg.sv
// ---------------------------------------------------------------------------
// sbe_pkg
// Types and constants shared by the segment box extruder and its checker.
// ---------------------------------------------------------------------------
package sbe_pkg;

	localparam int COORD_W   = 32;
	localparam int NORM_W    = 16;
	localparam int NORM_FRAC = 15;

	localparam logic signed [NORM_W-1:0] NORM_ONE  = 16'sh7fff;
	localparam logic signed [NORM_W-1:0] NORM_MONE = 16'sh8000;
	localparam logic [4:0]               LAST_VTX  = 5'd23;

	// Normal selection codes, one per face direction
	localparam logic [2:0] NK_TOP   = 3'd0;
	localparam logic [2:0] NK_BOT   = 3'd1;
	localparam logic [2:0] NK_LEFT  = 3'd2;
	localparam logic [2:0] NK_RIGHT = 3'd3;
	localparam logic [2:0] NK_FWD   = 3'd4;
	localparam logic [2:0] NK_BACK  = 3'd5;

	typedef struct packed {
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
		logic        [30:0]        width;
		logic signed [COORD_W-1:0] z_bottom;
		logic signed [COORD_W-1:0] z_top;
		logic        [31:0]        rgba;
	} seg_req_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic signed [NORM_W-1:0]  norm_x;
		logic signed [NORM_W-1:0]  norm_y;
		logic signed [NORM_W-1:0]  norm_z;
		logic        [31:0]        color_out;
		logic        [4:0]         vertex_number;
		logic                      last;
	} vtx_req_t;

	typedef struct packed {
		logic [1:0] corner;
		logic       hi;
		logic [2:0] kind;
	} vmap_t;

	// Saturate a widened sum to the coordinate range
	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [COORD_W+1:0] v);
		logic signed [COORD_W+1:0] hi_lim;
		logic signed [COORD_W+1:0] lo_lim;
		hi_lim = {3'b000, {(COORD_W-1){1'b1}}};
		lo_lim = {3'b111, {(COORD_W-1){1'b0}}};
		if (v > hi_lim) begin
			sat_coord = hi_lim[COORD_W-1:0];
		end else if (v < lo_lim) begin
			sat_coord = lo_lim[COORD_W-1:0];
		end else begin
			sat_coord = v[COORD_W-1:0];
		end
	endfunction

	// Corner, z level and normal for each of the 24 vertices
	function automatic vmap_t vtx_map(input logic [4:0] k);
		vmap_t m;
		case (k)
			5'd0:    m = '{2'd0, 1'b1, NK_TOP};
			5'd1:    m = '{2'd1, 1'b1, NK_TOP};
			5'd2:    m = '{2'd2, 1'b1, NK_TOP};
			5'd3:    m = '{2'd3, 1'b1, NK_TOP};
			5'd4:    m = '{2'd3, 1'b0, NK_BOT};
			5'd5:    m = '{2'd2, 1'b0, NK_BOT};
			5'd6:    m = '{2'd1, 1'b0, NK_BOT};
			5'd7:    m = '{2'd0, 1'b0, NK_BOT};
			5'd8:    m = '{2'd0, 1'b0, NK_LEFT};
			5'd9:    m = '{2'd1, 1'b0, NK_LEFT};
			5'd10:   m = '{2'd1, 1'b1, NK_LEFT};
			5'd11:   m = '{2'd0, 1'b1, NK_LEFT};
			5'd12:   m = '{2'd2, 1'b0, NK_RIGHT};
			5'd13:   m = '{2'd3, 1'b0, NK_RIGHT};
			5'd14:   m = '{2'd3, 1'b1, NK_RIGHT};
			5'd15:   m = '{2'd2, 1'b1, NK_RIGHT};
			5'd16:   m = '{2'd1, 1'b0, NK_FWD};
			5'd17:   m = '{2'd2, 1'b0, NK_FWD};
			5'd18:   m = '{2'd2, 1'b1, NK_FWD};
			5'd19:   m = '{2'd1, 1'b1, NK_FWD};
			5'd20:   m = '{2'd3, 1'b0, NK_BACK};
			5'd21:   m = '{2'd0, 1'b0, NK_BACK};
			5'd22:   m = '{2'd0, 1'b1, NK_BACK};
			5'd23:   m = '{2'd3, 1'b1, NK_BACK};
			default: m = '{2'd0, 1'b0, NK_TOP};
		endcase
		vtx_map = m;
	endfunction

endpackage

### design/sbe_sqrt.sv
// ---------------------------------------------------------------------------
// sbe_sqrt
// Iterative floor square root, two result bits per cycle.
// ---------------------------------------------------------------------------
module sbe_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  logic [62:0] rad,
	output logic        busy,
	output logic [31:0] root
);

	logic [63:0] rad_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [4:0]  cnt_q;

	logic [63:0] rad_n;
	logic [33:0] rem_n;
	logic [31:0] root_n;
	logic [35:0] r2;
	logic [35:0] trial;

	// Two restoring steps per cycle
	always_comb begin
		rad_n  = rad_q;
		rem_n  = rem_q;
		root_n = root_q;
		r2     = '0;
		trial  = '0;
		for (int i = 0; i < 2; i++) begin
			r2    = {rem_n, rad_n[63:62]};
			trial = {2'b00, root_n, 2'b01};
			rad_n = {rad_n[61:0], 2'b00};
			if (r2 >= trial) begin
				rem_n  = 34'(r2 - trial);
				root_n = {root_n[30:0], 1'b1};
			end else begin
				rem_n  = r2[33:0];
				root_n = {root_n[30:0], 1'b0};
			end
		end
	end

	// Count down the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= 5'd16;
		end else if (cnt_q != 5'd0) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	// Hold the datapath
	always_ff @(posedge clk) begin
		if (load) begin
			rad_q  <= {1'b0, rad};
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != 5'd0) begin
			rad_q  <= rad_n;
			rem_q  <= rem_n;
			root_q <= root_n;
		end
	end

	assign busy = (cnt_q != 5'd0);
	assign root = root_q;

endmodule

### design/sbe_div.sv
// ---------------------------------------------------------------------------
// sbe_div
// Iterative restoring divider: 63-bit numerator, 33-bit divisor, quotient
// known to fit 32 bits; two quotient bits per cycle.
// ---------------------------------------------------------------------------
module sbe_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  logic [62:0] num,
	input  logic [32:0] den,
	output logic        busy,
	output logic [31:0] quo
);

	logic [32:0] rem_q;
	logic [31:0] lo_q;
	logic [31:0] quo_q;
	logic [32:0] den_q;
	logic [4:0]  cnt_q;

	logic [32:0] rem_n;
	logic [31:0] lo_n;
	logic [31:0] quo_n;
	logic [33:0] r2;

	// Two long-division steps per cycle
	always_comb begin
		rem_n = rem_q;
		lo_n  = lo_q;
		quo_n = quo_q;
		r2    = '0;
		for (int i = 0; i < 2; i++) begin
			r2   = {rem_n, lo_n[31]};
			lo_n = {lo_n[30:0], 1'b0};
			if (r2 >= {1'b0, den_q}) begin
				rem_n = 33'(r2 - {1'b0, den_q});
				quo_n = {quo_n[30:0], 1'b1};
			end else begin
				rem_n = r2[32:0];
				quo_n = {quo_n[30:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= 5'd16;
		end else if (cnt_q != 5'd0) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= {2'b00, num[62:32]};
			lo_q  <= num[31:0];
			quo_q <= '0;
			den_q <= den;
		end else if (cnt_q != 5'd0) begin
			rem_q <= rem_n;
			lo_q  <= lo_n;
			quo_q <= quo_n;
		end
	end

	assign busy = (cnt_q != 5'd0);
	assign quo  = quo_q;

endmodule

### design/segment_box_extruder.sv
// ---------------------------------------------------------------------------
// segment_box_extruder
// Expands one track segment into the 24 vertices of its extruded box.
// ---------------------------------------------------------------------------
// Each accepted segment yields 24 vertices on the vtx channel, one per cycle
// while vtx_stall is low, so the output port sets the segment rate. Behind it
// sit three registered stages (difference, normalize, squares and products),
// an iterative square-root stage, an iterative divide stage (four dividers
// side by side) and a corner stage, so several segments are in flight at once.
// Segments of zero length or zero width produce nothing.
module segment_box_extruder import sbe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     seg_valid,
	output logic     seg_stall,
	input  seg_req_t seg,
	output logic     vtx_valid,
	input  logic     vtx_stall,
	output vtx_req_t vtx
);

	// ---------------- stage 1: differences ----------------
	logic            v_s1;
	seg_req_t        seg_s1;
	logic [32:0]     a_s1, b_s1;
	logic            ndx_s1, ndy_s1, skip_s1;
	logic signed [32:0] dx, dy;
	logic [32:0]     ax, by;

	// ---------------- stage 2: normalized magnitudes ----------------
	logic            v_s2;
	seg_req_t        seg_s2;
	logic [30:0]     an_s2, bn_s2;
	logic            ndx_s2, ndy_s2, skip_s2;
	logic [32:0]     mx;
	logic [4:0]      msb;
	logic [4:0]      lsh;
	logic [30:0]     an, bn;

	// ---------------- stage 3: squares and products ----------------
	logic            v_s3;
	seg_req_t        seg_s3;
	logic [30:0]     an_s3, bn_s3;
	logic [61:0]     sqa_s3, sqb_s3, wa_s3, wb_s3;
	logic            ndx_s3, ndy_s3, skip_s3;

	// ---------------- stage 4: square root ----------------
	logic            v_s4;
	seg_req_t        seg_s4;
	logic [30:0]     an_s4, bn_s4;
	logic [61:0]     wa_s4, wb_s4;
	logic            ndx_s4, ndy_s4, skip_s4;
	logic            sq_busy;
	logic [31:0]     len;

	// ---------------- stage 5: divisions ----------------
	logic            v_s5;
	seg_req_t        seg_s5;
	logic            ndx_s5, ndy_s5, skip_s5;
	logic [3:0]      dv_busy;
	logic [31:0]     q_tx, q_ty, q_ox, q_oy;

	// ---------------- stage 6: corners ----------------
	logic            v_s6;
	logic signed [COORD_W-1:0] px_s6 [4];
	logic signed [COORD_W-1:0] py_s6 [4];
	logic signed [NORM_W-1:0]  tx_s6, ty_s6;
	logic signed [COORD_W-1:0] zb_s6, zt_s6;
	logic [31:0]     col_s6;
	logic            skip_s6;
	logic [15:0]     txm, tym;
	logic signed [NORM_W-1:0]  tx, ty;
	logic signed [COORD_W+1:0] ox, oy;
	logic signed [COORD_W+1:0] sx, sy, ex, ey;
	logic signed [COORD_W-1:0] px [4];
	logic signed [COORD_W-1:0] py [4];

	// ---------------- emitter ----------------
	logic            e_v_q;
	logic [4:0]      cnt_q;
	logic signed [COORD_W-1:0] e_px_q [4];
	logic signed [COORD_W-1:0] e_py_q [4];
	logic signed [NORM_W-1:0]  e_tx_q, e_ty_q;
	logic signed [COORD_W-1:0] e_zb_q, e_zt_q;
	logic [31:0]     e_col_q;
	logic            out_v_q;
	vtx_req_t        out_q;
	vtx_req_t        vnext;
	vmap_t           vm;

	// ---------------- flow control ----------------
	logic out_ld, emit_can;
	logic take1, take2, take3, take4, take5, take6;
	logic can1, can2, can3, can4, can5, can6;
	logic sq_done, dv_done;

	assign sq_done  = !sq_busy;
	assign dv_done  = (dv_busy == 4'b0000);
	assign out_ld   = e_v_q && (!out_v_q || !vtx_stall);
	assign emit_can = skip_s6 || !e_v_q || ((cnt_q == LAST_VTX) && out_ld);
	assign take6    = v_s6 && emit_can;
	assign can6     = !v_s6 || take6;
	assign take5    = v_s5 && dv_done && can6;
	assign can5     = !v_s5 || take5;
	assign take4    = v_s4 && sq_done && can5;
	assign can4     = !v_s4 || take4;
	assign take3    = v_s3 && can4;
	assign can3     = !v_s3 || take3;
	assign take2    = v_s2 && can3;
	assign can2     = !v_s2 || take2;
	assign take1    = v_s1 && can2;
	assign can1     = !v_s1 || take1;
	assign seg_stall = !can1;

	// Advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (can1) v_s1 <= seg_valid;
			if (can2) v_s2 <= take1;
			if (can3) v_s3 <= take2;
			if (can4) v_s4 <= take3;
			if (can5) v_s5 <= take4;
			if (can6) v_s6 <= take5;
		end
	end

	// Stage 1: signed differences and their magnitudes
	assign dx = $signed({seg.end_x[31], seg.end_x}) - $signed({seg.start_x[31], seg.start_x});
	assign dy = $signed({seg.end_y[31], seg.end_y}) - $signed({seg.start_y[31], seg.start_y});
	assign ax = dx[32] ? 33'(-dx) : dx;
	assign by = dy[32] ? 33'(-dy) : dy;

	always_ff @(posedge clk) begin
		if (can1) begin
			seg_s1  <= seg;
			a_s1    <= ax;
			b_s1    <= by;
			ndx_s1  <= dx[32];
			ndy_s1  <= dy[32];
			skip_s1 <= ((dx == '0) && (dy == '0)) || (seg.width == '0);
		end
	end

	// Stage 2: bring the larger magnitude into [2^30, 2^31)
	always_comb begin
		mx  = (a_s1 > b_s1) ? a_s1 : b_s1;
		msb = '0;
		for (int i = 0; i < 31; i++) begin
			if (mx[i]) msb = 5'(i);
		end
		lsh = 5'd30 - msb;
		if (mx[32]) begin
			an = a_s1[32:2];
			bn = b_s1[32:2];
		end else if (mx[31]) begin
			an = a_s1[31:1];
			bn = b_s1[31:1];
		end else begin
			an = a_s1[30:0] << lsh;
			bn = b_s1[30:0] << lsh;
		end
	end

	always_ff @(posedge clk) begin
		if (can2) begin
			seg_s2  <= seg_s1;
			an_s2   <= an;
			bn_s2   <= bn;
			ndx_s2  <= ndx_s1;
			ndy_s2  <= ndy_s1;
			skip_s2 <= skip_s1;
		end
	end

	// Stage 3: squares for the length and width products for the offsets
	always_ff @(posedge clk) begin
		if (can3) begin
			seg_s3  <= seg_s2;
			an_s3   <= an_s2;
			bn_s3   <= bn_s2;
			sqa_s3  <= an_s2 * an_s2;
			sqb_s3  <= bn_s2 * bn_s2;
			wa_s3   <= seg_s2.width * an_s2;
			wb_s3   <= seg_s2.width * bn_s2;
			ndx_s3  <= ndx_s2;
			ndy_s3  <= ndy_s2;
			skip_s3 <= skip_s2;
		end
	end

	// Stage 4: length = floor(sqrt(a^2 + b^2))
	sbe_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (take3),
		.rad    (63'(sqa_s3) + 63'(sqb_s3)),
		.busy   (sq_busy),
		.root   (len)
	);

	always_ff @(posedge clk) begin
		if (take3) begin
			seg_s4  <= seg_s3;
			an_s4   <= an_s3;
			bn_s4   <= bn_s3;
			wa_s4   <= wa_s3;
			wb_s4   <= wb_s3;
			ndx_s4  <= ndx_s3;
			ndy_s4  <= ndy_s3;
			skip_s4 <= skip_s3;
		end
	end

	// Stage 5: rounded unit direction and half-width offsets
	sbe_div u_div_tx (
		.clk (clk), .arst_n (arst_n), .load (take4),
		.num ({17'd0, an_s4, 15'd0} + 63'(len[31:1])),
		.den ({1'b0, len}), .busy (dv_busy[0]), .quo (q_tx)
	);

	sbe_div u_div_ty (
		.clk (clk), .arst_n (arst_n), .load (take4),
		.num ({17'd0, bn_s4, 15'd0} + 63'(len[31:1])),
		.den ({1'b0, len}), .busy (dv_busy[1]), .quo (q_ty)
	);

	sbe_div u_div_ox (
		.clk (clk), .arst_n (arst_n), .load (take4),
		.num (63'(wa_s4) + 63'(len)),
		.den ({len, 1'b0}), .busy (dv_busy[2]), .quo (q_ox)
	);

	sbe_div u_div_oy (
		.clk (clk), .arst_n (arst_n), .load (take4),
		.num (63'(wb_s4) + 63'(len)),
		.den ({len, 1'b0}), .busy (dv_busy[3]), .quo (q_oy)
	);

	always_ff @(posedge clk) begin
		if (take4) begin
			seg_s5  <= seg_s4;
			ndx_s5  <= ndx_s4;
			ndy_s5  <= ndy_s4;
			skip_s5 <= skip_s4;
		end
	end

	// Stage 6: saturate the normal, apply signs, form the four corners
	always_comb begin
		txm = (q_tx > 32'd32767) ? 16'h7fff : q_tx[15:0];
		tym = (q_ty > 32'd32767) ? 16'h7fff : q_ty[15:0];
		tx  = ndx_s5 ? -$signed(txm) : $signed(txm);
		ty  = ndy_s5 ? -$signed(tym) : $signed(tym);
		ox  = ndx_s5 ? -$signed({2'b00, q_ox}) : $signed({2'b00, q_ox});
		oy  = ndy_s5 ? -$signed({2'b00, q_oy}) : $signed({2'b00, q_oy});
		sx  = 34'(seg_s5.start_x);
		sy  = 34'(seg_s5.start_y);
		ex  = 34'(seg_s5.end_x);
		ey  = 34'(seg_s5.end_y);
		px[0] = sat_coord(sx - oy);
		py[0] = sat_coord(sy + ox);
		px[1] = sat_coord(ex - oy);
		py[1] = sat_coord(ey + ox);
		px[2] = sat_coord(ex + oy);
		py[2] = sat_coord(ey - ox);
		px[3] = sat_coord(sx + oy);
		py[3] = sat_coord(sy - ox);
	end

	always_ff @(posedge clk) begin
		if (take5) begin
			px_s6   <= px;
			py_s6   <= py;
			tx_s6   <= tx;
			ty_s6   <= ty;
			zb_s6   <= seg_s5.z_bottom;
			zt_s6   <= seg_s5.z_top;
			col_s6  <= seg_s5.rgba;
			skip_s6 <= skip_s5;
		end
	end

	// Emitter: step through the 24 vertices, drop skipped segments
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_v_q <= 1'b0;
			cnt_q <= '0;
		end else if (take6 && !skip_s6) begin
			e_v_q <= 1'b1;
			cnt_q <= '0;
		end else if (out_ld) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == LAST_VTX) e_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take6 && !skip_s6) begin
			e_px_q  <= px_s6;
			e_py_q  <= py_s6;
			e_tx_q  <= tx_s6;
			e_ty_q  <= ty_s6;
			e_zb_q  <= zb_s6;
			e_zt_q  <= zt_s6;
			e_col_q <= col_s6;
		end
	end

	// Build the next vertex
	always_comb begin
		vm                  = vtx_map(cnt_q);
		vnext.pos_x         = e_px_q[vm.corner];
		vnext.pos_y         = e_py_q[vm.corner];
		vnext.pos_z         = vm.hi ? e_zt_q : e_zb_q;
		vnext.color_out     = e_col_q;
		vnext.vertex_number = cnt_q;
		vnext.last          = (cnt_q == LAST_VTX);
		case (vm.kind)
			NK_TOP: begin
				vnext.norm_x = '0;
				vnext.norm_y = '0;
				vnext.norm_z = NORM_ONE;
			end
			NK_BOT: begin
				vnext.norm_x = '0;
				vnext.norm_y = '0;
				vnext.norm_z = NORM_MONE;
			end
			NK_LEFT: begin
				vnext.norm_x = -e_ty_q;
				vnext.norm_y = e_tx_q;
				vnext.norm_z = '0;
			end
			NK_RIGHT: begin
				vnext.norm_x = e_ty_q;
				vnext.norm_y = -e_tx_q;
				vnext.norm_z = '0;
			end
			NK_FWD: begin
				vnext.norm_x = e_tx_q;
				vnext.norm_y = e_ty_q;
				vnext.norm_z = '0;
			end
			NK_BACK: begin
				vnext.norm_x = -e_tx_q;
				vnext.norm_y = -e_ty_q;
				vnext.norm_z = '0;
			end
			default: begin
				vnext.norm_x = '0;
				vnext.norm_y = '0;
				vnext.norm_z = '0;
			end
		endcase
	end

	// Output register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_ld) begin
			out_v_q <= 1'b1;
		end else if (!vtx_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) out_q <= vnext;
	end

	assign vtx_valid = out_v_q;
	assign vtx       = out_q;

endmodule

### design/sbe_checker.sv
// ---------------------------------------------------------------------------
// sbe_checker
// Port-level checks for the segment box extruder, bound to the top level.
// ---------------------------------------------------------------------------
module sbe_checker import sbe_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     seg_valid,
	input logic     seg_stall,
	input seg_req_t seg,
	input logic     vtx_valid,
	input logic     vtx_stall,
	input vtx_req_t vtx
);

	// A stalled segment request holds
	a_seg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && seg_stall |=> seg_valid && $stable(seg))
		else $error("segment request changed while stalled");

	// A stalled request holds
	a_vtx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_valid && vtx_stall |=> vtx_valid && $stable(vtx))
		else $error("vertex request changed while stalled");

	// Last flag marks vertex 23 only
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_valid |-> (vtx.vertex_number <= LAST_VTX) &&
			(vtx.last == (vtx.vertex_number == LAST_VTX)))
		else $error("bad vertex number or last flag");

	// Vertices follow in order within a segment
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_valid && !vtx_stall && !vtx.last ##1 vtx_valid |->
			vtx.vertex_number == $past(vtx.vertex_number) + 5'd1)
		else $error("vertex out of order");

	// Face normals are vertical, side normals flat
	a_norm: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_valid |-> ((vtx.vertex_number < 5'd4) ? (vtx.norm_z == NORM_ONE) :
			(vtx.vertex_number < 5'd8) ? (vtx.norm_z == NORM_MONE) :
			(vtx.norm_z == '0)))
		else $error("bad normal z");

endmodule

bind segment_box_extruder sbe_checker u_sbe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.seg_valid (seg_valid),
	.seg_stall (seg_stall),
	.seg       (seg),
	.vtx_valid (vtx_valid),
	.vtx_stall (vtx_stall),
	.vtx       (vtx)
);

### tb/segment_box_extruder_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// segment_box_extruder_tb
// Drives track segments into the extruder and checks every box vertex that
// comes out against a local fixed-point prediction, under varied idling.
// ---------------------------------------------------------------------------
module segment_box_extruder_tb;
	import sbe_pkg::*;

	localparam int LAT = 80;

	typedef struct {
		seg_req_t seg;
		logic     has_fixed;
		vtx_req_t fixed_v0;
	} row_t;

	logic     clk;
	logic     arst_n;
	logic     seg_valid;
	logic     seg_stall;
	seg_req_t seg;
	logic     vtx_valid;
	logic     vtx_stall;
	vtx_req_t vtx;

	vtx_req_t vertex_q[$];
	int       fail_count;
	int       send_idle_pct;
	int       recv_stall_pct;
	row_t     rows[$];

	segment_box_extruder u_dut (
		.clk(clk), .arst_n(arst_n),
		.seg_valid(seg_valid), .seg_stall(seg_stall), .seg(seg),
		.vtx_valid(vtx_valid), .vtx_stall(vtx_stall), .vtx(vtx)
	);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[COORD_W-1:0];
	endfunction

	function automatic longint unsigned root_floor(input longint unsigned v);
		longint unsigned r, bit_v;
		r = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > v) bit_v >>= 2;
		while (bit_v != 0) begin
			if (v >= r + bit_v) begin
				v -= r + bit_v;
				r = (r >> 1) + bit_v;
			end else begin
				r >>= 1;
			end
			bit_v >>= 2;
		end
		return r;
	endfunction

	// Compute the 24 box vertices of one segment and queue them
	task automatic predict_box(input seg_req_t s);
		longint sx, sy, ex, ey, dx, dy, tx, ty, ox, oy;
		longint unsigned a, b, m, len, txm, tym, oxm, oym, w;
		longint px[4], py[4], nxs[4], nys[4];
		int ca[4], cb[4], p;
		vtx_req_t v;
		int k;
		sx = s.start_x; sy = s.start_y; ex = s.end_x; ey = s.end_y;
		w = s.width;
		dx = ex - sx; dy = ey - sy;
		if ((dx == 0 && dy == 0) || w == 0) return;
		a = (dx < 0) ? -dx : dx;
		b = (dy < 0) ? -dy : dy;
		m = (a > b) ? a : b;
		while (m >= (64'd1 << 31)) begin a >>= 1; b >>= 1; m >>= 1; end
		while (m < (64'd1 << 30)) begin a <<= 1; b <<= 1; m <<= 1; end
		len = root_floor(a * a + b * b);
		txm = ((a << NORM_FRAC) + len / 2) / len;
		tym = ((b << NORM_FRAC) + len / 2) / len;
		if (txm > 32767) txm = 32767;
		if (tym > 32767) tym = 32767;
		tx = (dx < 0) ? -longint'(txm) : longint'(txm);
		ty = (dy < 0) ? -longint'(tym) : longint'(tym);
		oxm = (w * a + len) / (2 * len);
		oym = (w * b + len) / (2 * len);
		ox = (dx < 0) ? -longint'(oxm) : longint'(oxm);
		oy = (dy < 0) ? -longint'(oym) : longint'(oym);
		px[0] = sx - oy; py[0] = sy + ox;
		px[1] = ex - oy; py[1] = ey + ox;
		px[2] = ex + oy; py[2] = ey - ox;
		px[3] = sx + oy; py[3] = sy - ox;
		nxs = '{-ty, ty, tx, -tx};
		nys = '{tx, -tx, ty, -ty};
		ca = '{0, 2, 1, 3};
		cb = '{1, 3, 2, 0};
		v.color_out = s.rgba;
		for (k = 0; k < 24; k++) begin
			if (k < 8) begin
				p = (k < 4) ? k : 7 - k;
				v.pos_z = (k < 4) ? s.z_top : s.z_bottom;
				v.norm_x = '0; v.norm_y = '0;
				v.norm_z = (k < 4) ? NORM_ONE : NORM_MONE;
			end else begin
				case ((k - 8) % 4)
					0, 3: p = ca[(k - 8) / 4];
					default: p = cb[(k - 8) / 4];
				endcase
				v.pos_z = ((k - 8) % 4 < 2) ? s.z_bottom : s.z_top;
				v.norm_x = 16'(nxs[(k - 8) / 4]);
				v.norm_y = 16'(nys[(k - 8) / 4]);
				v.norm_z = '0;
			end
			v.pos_x = clamp_coord(px[p]);
			v.pos_y = clamp_coord(py[p]);
			v.vertex_number = 5'(k);
			v.last = (k == 23);
			vertex_q = {vertex_q, v};
		end
	endtask

	// Hand one request to the block and queue what it should produce
	task automatic send_segment(input seg_req_t s);
		while ($urandom_range(99) < send_idle_pct) begin
			seg_valid <= 1'b0;
			@(posedge clk);
		end
		seg_valid <= 1'b1;
		seg <= s;
		@(posedge clk);
		while (seg_stall) @(posedge clk);
		predict_box(s);
	endtask

	function automatic seg_req_t random_segment();
		seg_req_t s;
		int mode;
		s = 255'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom});
		mode = $urandom_range(9);
		if (mode < 5) begin
			// modest geometry
			s.end_x = s.start_x + $signed($urandom_range(20000)) - 10000;
			s.end_y = s.start_y + $signed($urandom_range(20000)) - 10000;
			s.width = 31'($urandom_range(5000));
		end else if (mode == 5) begin
			s.end_x = s.start_x;
			s.end_y = s.start_y;
		end else if (mode == 6) begin
			s.width = '0;
		end else if (mode == 7) begin
			s.end_x = s.start_x + $signed($urandom_range(3)) - 1;
			s.end_y = s.start_y;
		end
		return s;
	endfunction

	// Check each accepted vertex against the oldest prediction
	always @(posedge clk) begin
		vtx_req_t e;
		if (arst_n && vtx_valid && !vtx_stall) begin
			if (vertex_q.size() == 0) begin
				report_mismatch("unexpected vertex", vtx.vertex_number, -1);
			end else begin
				e = vertex_q.pop_front();
				if (vtx.pos_x !== e.pos_x) report_mismatch("pos_x", vtx.pos_x, e.pos_x);
				if (vtx.pos_y !== e.pos_y) report_mismatch("pos_y", vtx.pos_y, e.pos_y);
				if (vtx.pos_z !== e.pos_z) report_mismatch("pos_z", vtx.pos_z, e.pos_z);
				if (vtx.norm_x !== e.norm_x) report_mismatch("norm_x", vtx.norm_x, e.norm_x);
				if (vtx.norm_y !== e.norm_y) report_mismatch("norm_y", vtx.norm_y, e.norm_y);
				if (vtx.norm_z !== e.norm_z) report_mismatch("norm_z", vtx.norm_z, e.norm_z);
				if (vtx.color_out !== e.color_out)
					report_mismatch("color_out", vtx.color_out, e.color_out);
				if (vtx.vertex_number !== e.vertex_number)
					report_mismatch("vertex_number", vtx.vertex_number, e.vertex_number);
				if (vtx.last !== e.last) report_mismatch("last", vtx.last, e.last);
			end
		end
	end

	// Stall the vertex side at random
	always @(posedge clk) begin
		vtx_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	initial begin
		#50ms;
		$display("Test completed with failures");
		$finish;
	end

	function automatic row_t mk_row(input seg_req_t s, input logic fx, input vtx_req_t v0);
		row_t r;
		r.seg = s; r.has_fixed = fx; r.fixed_v0 = v0;
		return r;
	endfunction

	initial begin
		seg_req_t s;
		vtx_req_t v0;
		int n, phase, guard;
		arst_n = 1'b0;
		seg_valid = 1'b0;
		seg = '0;
		fail_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: unit axis segments have known first vertices
		s = '{0, 0, 1000, 0, 200, -5, 7, 32'hdeadbeef};
		v0 = '{0, 100, 7, 0, 0, NORM_ONE, 32'hdeadbeef, 0, 0};
		rows = {rows, mk_row(s, 1, v0)};
		s = '{0, 0, 0, 1000, 200, -5, 7, 32'h00000000};
		v0 = '{-100, 0, 7, 0, 0, NORM_ONE, 32'h0, 0, 0};
		rows = {rows, mk_row(s, 1, v0)};
		s = '{32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
			31'h7fffffff, 32'sh80000000, 32'sh7fffffff, 32'hffffffff};
		rows = {rows, mk_row(s, 0, v0)};
		s = '{32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
			31'h7fffffff, 32'sh7fffffff, 32'sh80000000, 32'h5a5aa5a5};
		rows = {rows, mk_row(s, 0, v0)};
		rows = {rows, mk_row('{5, 5, 5, 5, 100, 0, 1, 1}, 0, v0)};
		rows = {rows, mk_row('{5, 5, 9, 5, 0, 0, 1, 1}, 0, v0)};
		rows = {rows, mk_row('{0, 0, 1, 0, 1, 0, 1, 2}, 0, v0)};
		rows = {rows, mk_row('{0, 0, -1, -1, 3, 10, -10, 3}, 0, v0)};
		rows = {rows, mk_row('{0, 0, 3, 4, 1000, 0, 1, 4}, 0, v0)};
		rows = {rows, mk_row('{100, 100, -300, 100, 50, 0, 1, 5}, 0, v0)};
		rows = {rows, mk_row('{0, 32'sh7fffff00, 0, 32'sh80000100, 31'h7fffffff, 0, 0, 6},
			0, v0)};
		foreach (rows[i]) begin
			send_segment(rows[i].seg);
			// first vertex of the newest box must also equal the hand value
			if (rows[i].has_fixed) begin
				if (vertex_q[vertex_q.size() - 24] !== rows[i].fixed_v0)
					report_mismatch("directed row", i, -1);
			end
		end
		seg_valid <= 1'b0;

		// pause until every vertex is back
		guard = 0;
		while (vertex_q.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end

		for (phase = 0; phase < 4; phase++) begin
			send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 12 : 85) : 0;
			recv_stall_pct = (phase == 2) ? 85 : ((phase == 3) ? 12 : 0);
			for (n = 0; n < 92; n++) send_segment(random_segment());
		end
		seg_valid <= 1'b0;
		recv_stall_pct = 0;

		while (vertex_q.size() != 0) @(posedge clk);
		repeat (LAT) @(posedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

### files.f
design/sbe_pkg.sv
design/sbe_sqrt.sv
design/sbe_div.sv
design/segment_box_extruder.sv
design/sbe_checker.sv
tb/segment_box_extruder_tb.sv
